/* hw/rtl/mtpu_pkg.sv */
`timescale 1ns / 1ps

package mtpu_pkg;

	// Register file is fixed at five step amounts plus the select count.
	localparam int MAX_SCALES = 5;

	localparam int PIX_W  = 18;
	localparam int VAR_W  = 16;
	localparam int MAG_W  = 17;
	localparam int AMT_W  = 14;
	localparam int CNT_W  = 3;
	localparam int CON_W  = 15;
	localparam int SUM_W  = 18;
	localparam int REC_W  = 22;
	localparam int REC_SH = 21;
	localparam int OUT_W  = 24;

	localparam logic [CNT_W-1:0] SELECT_COUNT_RESET = 3'd1;
	localparam logic [AMT_W-1:0] STEP_AMOUNT_RESET  = 14'd819;

	typedef enum logic [2:0] {
		REG_SELECT_COUNT,
		REG_STEP_AMOUNT_0,
		REG_STEP_AMOUNT_1,
		REG_STEP_AMOUNT_2,
		REG_STEP_AMOUNT_3,
		REG_STEP_AMOUNT_4
	} reg_idx_t;

	typedef logic signed [PIX_W-1:0] pix_t;
	typedef logic signed [VAR_W-1:0] var_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [AMT_W-1:0] amt_t;
	typedef logic signed [CON_W-1:0] contrib_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// Per-scale view handed to the rank logic.
	typedef struct packed {
		mag_t mag;
		logic pos;
		logic neg;
	} scale_t;

	// ceil(2^21 / n): exact truncating quotient for dividends below 2^17.
	function automatic logic [REC_W-1:0] recip(logic [CNT_W-1:0] n);
		logic [REC_W-1:0] r;
		case (n)
			3'd1:    r = 22'd2097152;
			3'd2:    r = 22'd1048576;
			3'd3:    r = 22'd699051;
			3'd4:    r = 22'd524288;
			3'd5:    r = 22'd419431;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/mtpu_rank.sv */
`timescale 1ns / 1ps

// Picks the n smallest magnitudes (lower index wins a tie) and forms
// the signed step of each chosen scale.
module mtpu_rank import mtpu_pkg::*; #(
	parameter int SCALE_COUNT = 5
) (
	input  scale_t           scl     [SCALE_COUNT],
	input  amt_t             amt     [SCALE_COUNT],
	input  logic [CNT_W-1:0] n,
	output contrib_t         contrib [SCALE_COUNT]
);

	always_comb begin
		logic [CNT_W-1:0] rank;
		for (int i = 0; i < SCALE_COUNT; i++) begin
			rank = '0;
			for (int j = 0; j < SCALE_COUNT; j++) begin
				if (scl[j].mag < scl[i].mag || (scl[j].mag == scl[i].mag && j < i)) begin
					rank = rank + 3'd1;
				end
			end
			if (rank < n && scl[i].pos) begin
				contrib[i] = $signed({1'b0, amt[i]});
			end else if (rank < n && scl[i].neg) begin
				contrib[i] = -$signed({1'b0, amt[i]});
			end else begin
				contrib[i] = '0;
			end
		end
	end

endmodule

/* hw/rtl/multiscale_turing_pixel_update_unit.sv */
`timescale 1ns / 1ps

// Multiscale Turing pattern pixel update.
// s_* : input request, s_tdata = pixel_value Q3.14 and one Q1.14 variation per scale.
// m_* : result request, m_tdata = updated_pixel Q3.14, m_tuser = saturated.
// cfg_*: register writes, index 0 select_count, 1..5 step_amount_0..4.
//        Write only while the pipeline is empty; cfg_ready is always high.
// Five register stages: magnitudes, ranking and signed steps, sum,
// reciprocal multiply for the divide by select_count, add and saturate.
// An accepted pixel passes the stage registers s1 to s5 before m_tvalid
// shows it; one pixel per cycle sustained while m_tready stays high.
// Each stage moves when the next one is empty or moving, so bubbles
// collapse and input is taken while a result waits at the output.
// When m_tready stays low the pipeline fills and s_tready drops after
// five pixels; nothing is lost or repeated.
// Reset empties the pipeline, sets select_count to 1 and every step to 819.
module multiscale_turing_pixel_update_unit import mtpu_pkg::*; #(
	parameter int SCALE_COUNT = 5,
	localparam int IN_W = ((PIX_W + VAR_W * SCALE_COUNT + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// [17:0] pixel_value, then variation_0.. 16 bits each, zero padded
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// [17:0] updated_pixel, zero padded
	output logic [OUT_W-1:0]  m_tdata,
	// [0] saturated
	output logic              m_tuser,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [AMT_W-1:0]  cfg_data
);

	// ---------------- configuration registers ----------------
	logic [CNT_W-1:0] select_count_q;
	amt_t             step_q [MAX_SCALES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_count_q <= SELECT_COUNT_RESET;
			for (int k = 0; k < MAX_SCALES; k++) begin
				step_q[k] <= STEP_AMOUNT_RESET;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SELECT_COUNT:  select_count_q <= cfg_data[CNT_W-1:0];
				REG_STEP_AMOUNT_0: step_q[0] <= cfg_data;
				REG_STEP_AMOUNT_1: step_q[1] <= cfg_data;
				REG_STEP_AMOUNT_2: step_q[2] <= cfg_data;
				REG_STEP_AMOUNT_3: step_q[3] <= cfg_data;
				REG_STEP_AMOUNT_4: step_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Counts above the scale number clamp to the scale number.
	logic [CNT_W-1:0] n_eff;
	assign n_eff = (select_count_q > CNT_W'(SCALE_COUNT)) ? CNT_W'(SCALE_COUNT)
		: select_count_q;

	// ---------------- pipeline flow control ----------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !valid_s5 || m_tready;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= s_tvalid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
		end
	end

	// ---------------- stage 1: magnitudes and signs ----------------
	pix_t             pix_s1;
	scale_t           scl_s1 [SCALE_COUNT];
	logic [CNT_W-1:0] n_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			var_t v;
			pix_s1 <= s_tdata[PIX_W-1:0];
			n_s1   <= n_eff;
			for (int i = 0; i < SCALE_COUNT; i++) begin
				v = s_tdata[PIX_W + VAR_W*i +: VAR_W];
				// -32768 yields 32768, larger than any other magnitude
				scl_s1[i].mag <= v[VAR_W-1] ? (MAG_W'(0) - {v[VAR_W-1], v})
					: {1'b0, v};
				scl_s1[i].neg <= v[VAR_W-1];
				scl_s1[i].pos <= !v[VAR_W-1] && (v != '0);
			end
		end
	end

	// ---------------- stage 2: rank and signed steps ----------------
	amt_t     amt_sel [SCALE_COUNT];
	contrib_t contrib [SCALE_COUNT];

	always_comb begin
		for (int i = 0; i < SCALE_COUNT; i++) begin
			amt_sel[i] = step_q[i];
		end
	end

	mtpu_rank #(
		.SCALE_COUNT(SCALE_COUNT)
	) u_rank (
		.scl     (scl_s1),
		.amt     (amt_sel),
		.n       (n_s1),
		.contrib (contrib)
	);

	pix_t             pix_s2;
	contrib_t         contrib_s2 [SCALE_COUNT];
	logic [CNT_W-1:0] n_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			pix_s2     <= pix_s1;
			n_s2       <= n_s1;
			contrib_s2 <= contrib;
		end
	end

	// ---------------- stage 3: sum of steps ----------------
	sum_t sum_c;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < SCALE_COUNT; i++) begin
			sum_c = sum_c + SUM_W'(contrib_s2[i]);
		end
	end

	pix_t             pix_s3;
	sum_t             sum_s3;
	logic [CNT_W-1:0] n_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			pix_s3 <= pix_s2;
			sum_s3 <= sum_c;
			n_s3   <= n_s2;
		end
	end

	// ---------------- stage 4: |sum| times reciprocal ----------------
	// |sum| < 2^17, so the product stays below 2^38.
	localparam int PROD_W = MAG_W + REC_SH;

	logic [MAG_W-1:0] sum_abs;
	assign sum_abs = sum_s3[SUM_W-1] ? (MAG_W'(0) - sum_s3[MAG_W-1:0]) : sum_s3[MAG_W-1:0];

	pix_t              pix_s4;
	logic              neg_s4;
	logic [PROD_W-1:0] prod_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			pix_s4  <= pix_s3;
			neg_s4  <= sum_s3[SUM_W-1];
			prod_s4 <= PROD_W'(PROD_W'(sum_abs) * PROD_W'(recip(n_s3)));
		end
	end

	// ---------------- stage 5: add and saturate ----------------
	localparam int RES_W = PIX_W + 2;

	logic [MAG_W-1:0]        quot;
	logic signed [RES_W-1:0] res;
	logic signed [RES_W-1:0] quot_s;
	pix_t                    res_sat;
	logic                    sat_c;

	assign quot   = prod_s4[PROD_W-1:REC_SH];
	assign quot_s = neg_s4 ? -$signed({3'b000, quot}) : $signed({3'b000, quot});
	assign res    = RES_W'(pix_s4) + quot_s;

	always_comb begin
		if (res > RES_W'(131071)) begin
			res_sat = 18'sh1FFFF;
			sat_c   = 1'b1;
		end else if (res < -RES_W'(131072)) begin
			res_sat = 18'sh20000;
			sat_c   = 1'b1;
		end else begin
			res_sat = res[PIX_W-1:0];
			sat_c   = 1'b0;
		end
	end

	pix_t upd_s5;
	logic sat_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			upd_s5 <= res_sat;
			sat_s5 <= sat_c;
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = {{(OUT_W - PIX_W){1'b0}}, upd_s5};
	assign m_tuser  = sat_s5;

	// ---------------- checks ----------------
	logic [SCALE_COUNT-1:0] nz_s2;

	always_comb begin
		for (int i = 0; i < SCALE_COUNT; i++) begin
			nz_s2[i] = (contrib_s2[i] != '0);
		end
	end

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && !m_tready))
		else $error("input stalled with room in the pipeline");

	a_no_count_no_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && n_s3 == '0) |-> (sum_s3 == '0))
		else $error("nonzero sum with select count zero");

	a_chosen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ($countones(nz_s2) <= n_s2))
		else $error("more scales contribute than selected");

	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (upd_s5 == 18'sh1FFFF || upd_s5 == 18'sh20000))
		else $error("saturation flag without rail value");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Pixel update unit: directed corner cases, then randomized config phases.
// Predicted pixels are computed at input accept time from the shadow
// config and compared in order against the result stream.
module testbench;
	import mtpu_pkg::*;

	localparam int SCALES  = 5;
	localparam int TDATA_W = ((PIX_W + VAR_W * SCALES + 7) / 8) * 8;
	localparam int VARS_W  = VAR_W * SCALES;
	localparam int PIX_HI  = 2 ** (PIX_W - 1) - 1;
	localparam int PIX_LO  = -(2 ** (PIX_W - 1));
	localparam int VAR_HI  = 2 ** (VAR_W - 1) - 1;
	localparam int VAR_LO  = -(2 ** (VAR_W - 1));
	localparam amt_t AMT_MAX = '1;
	// Indexes past the register file; writes there must be dropped.
	localparam logic [2:0] IDX_SPARE_6 = 3'd6;
	localparam logic [2:0] IDX_SPARE_7 = 3'd7;
	localparam int RANDOM_PHASES   = 10;
	localparam int ITEMS_PER_PHASE = 85;

	typedef struct packed {
		pix_t pixel;
		logic sat;
	} pixel_result_t;

	logic clk;
	logic arst_n = 1'b0;

	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;
	logic               m_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [AMT_W-1:0]   cfg_data = '0;

	// Shadow copy of the register file, tracked from accepted writes.
	logic [CNT_W-1:0] shadow_select;
	amt_t             shadow_steps [SCALES];

	pixel_result_t pending_pixels [$];
	int unsigned   pixels_sent;
	int unsigned   pixels_done;
	int unsigned   mismatches;
	// When set, neither side inserts gaps (back-to-back streaming).
	bit            no_stall;

	multiscale_turing_pixel_update_unit #(
		.SCALE_COUNT(SCALES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case a request or result never shows up.
	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

	// Pick the smallest-magnitude scales (ties to lower index), sum their
	// signed steps, divide by the count toward zero, add and clip.
	function automatic pixel_result_t predict_update(input logic [TDATA_W-1:0] word);
		pix_t p;
		var_t v;
		int px, n, sum, res, rank;
		int vals [SCALES];
		int mags [SCALES];
		pixel_result_t r;
		p = word[PIX_W-1:0];
		px = p;
		for (int i = 0; i < SCALES; i++) begin
			v = word[PIX_W + i * VAR_W +: VAR_W];
			vals[i] = v;
			mags[i] = (vals[i] < 0) ? -vals[i] : vals[i];
		end
		n = (int'(shadow_select) > SCALES) ? SCALES : int'(shadow_select);
		res = px;
		r.sat = 1'b0;
		if (n > 0) begin
			sum = 0;
			for (int i = 0; i < SCALES; i++) begin
				rank = 0;
				for (int j = 0; j < SCALES; j++)
					if (mags[j] < mags[i] || (mags[j] == mags[i] && j < i))
						rank++;
				if (rank < n) begin
					if (vals[i] > 0)
						sum = sum + int'(shadow_steps[i]);
					else if (vals[i] < 0)
						sum = sum - int'(shadow_steps[i]);
				end
			end
			res = px + sum / n;
			if (res > PIX_HI) begin
				res = PIX_HI;
				r.sat = 1'b1;
			end else if (res < PIX_LO) begin
				res = PIX_LO;
				r.sat = 1'b1;
			end
		end
		r.pixel = pix_t'(res);
		return r;
	endfunction

	// Tracks config writes, predicts on every input request, checks every
	// result request against the oldest prediction.
	always @(posedge clk) begin : scoreboard
		pixel_result_t want;
		pix_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SELECT_COUNT)
					shadow_select = cfg_data[CNT_W-1:0];
				else if (cfg_index >= REG_STEP_AMOUNT_0 && cfg_index <= REG_STEP_AMOUNT_4)
					shadow_steps[cfg_index - REG_STEP_AMOUNT_0] = cfg_data;
			end
			if (s_tvalid && s_tready)
				pending_pixels.push_back(predict_update(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[PIX_W-1:0];
				if (pending_pixels.size() == 0) begin
					$error("updated_pixel: no result expected, actual %0d", got);
					mismatches++;
				end else begin
					want = pending_pixels.pop_front();
					if (got !== want.pixel) begin
						$error("updated_pixel: expected %0d, actual %0d", want.pixel, got);
						mismatches++;
					end
					if (m_tuser !== want.sat) begin
						$error("saturated: expected %0b, actual %0b", want.sat, m_tuser);
						mismatches++;
					end
					if (m_tdata[OUT_W-1:PIX_W] !== '0) begin
						$error("m_tdata padding: expected 0, actual %0h",
							m_tdata[OUT_W-1:PIX_W]);
						mismatches++;
					end
					pixels_done++;
				end
			end
		end
	end

	// Result side: random backpressure before each accept.
	initial begin : result_sink
		int gap;
		@(posedge arst_n);
		forever begin
			gap = no_stall ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// One input request; valid stays high if the next call follows at once.
	task automatic send_pixel(input pix_t px, input logic [VARS_W-1:0] vars);
		int gap;
		logic [TDATA_W-1:0] word;
		gap = no_stall ? 0 : $urandom_range(0, 3);
		word = '0;
		word[PIX_W-1:0] = px;
		word[PIX_W +: VARS_W] = vars;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	// Drop valid and wait until every accepted pixel has come back.
	task automatic wait_drained();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		while (pixels_done != pixels_sent) @(posedge clk);
	endtask

	// Caller lowers cfg_valid after its last write.
	task automatic write_reg(input logic [2:0] idx, input logic [AMT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Full register set; upper bits of the count word are random junk
	// that the block has to ignore.
	task automatic apply_config(input logic [CNT_W-1:0] sel, input logic [AMT_W*SCALES-1:0] steps);
		logic [AMT_W-1:0] sel_word;
		wait_drained();
		sel_word = AMT_W'($urandom);
		sel_word[CNT_W-1:0] = sel;
		write_reg(REG_SELECT_COUNT, sel_word);
		for (int i = 0; i < SCALES; i++)
			write_reg(3'(REG_STEP_AMOUNT_0 + i), steps[i * AMT_W +: AMT_W]);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VARS_W-1:0] vpack(input var_t v0, input var_t v1,
			input var_t v2, input var_t v3, input var_t v4);
		return {v4, v3, v2, v1, v0};
	endfunction

	function automatic logic [AMT_W*SCALES-1:0] spack(input amt_t a0, input amt_t a1,
			input amt_t a2, input amt_t a3, input amt_t a4);
		return {a4, a3, a2, a1, a0};
	endfunction

	function automatic pix_t rand_pixel();
		case ($urandom_range(0, 4))
			0:       return pix_t'(PIX_HI - int'($urandom_range(0, 20000)));
			1:       return pix_t'(PIX_LO + int'($urandom_range(0, 20000)));
			default: return pix_t'($urandom);
		endcase
	endfunction

	// Mix of extremes, tiny values (lots of magnitude ties) and full range.
	function automatic var_t rand_variation();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0:       return var_t'(VAR_LO);
					1:       return var_t'(VAR_HI);
					2:       return var_t'(-VAR_HI);
					3:       return var_t'(1);
					4:       return var_t'(-1);
					default: return var_t'(0);
				endcase
			end
			1, 2, 3: return var_t'(int'($urandom_range(0, 8)) - 4);
			default: return var_t'($urandom);
		endcase
	endfunction

	function automatic logic [VARS_W-1:0] rand_vars();
		logic [VARS_W-1:0] vars;
		for (int i = 0; i < SCALES; i++)
			vars[i * VAR_W +: VAR_W] = rand_variation();
		return vars;
	endfunction

	function automatic amt_t rand_step();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return AMT_MAX;
			default: return amt_t'($urandom);
		endcase
	endfunction

	// Out of reset: count 1, every step 819.
	task automatic test_reset_values();
		for (int i = 0; i < 5; i++)
			send_pixel(rand_pixel(), rand_vars());
	endtask

	task automatic test_special_cases();
		// All scales, max steps: clip at both ends of the pixel range.
		apply_config(3'd5, {SCALES{AMT_MAX}});
		send_pixel(pix_t'(PIX_HI), vpack(VAR_HI, VAR_HI, VAR_HI, VAR_HI, VAR_HI));
		send_pixel(pix_t'(PIX_LO), vpack(VAR_LO, VAR_LO, VAR_LO, VAR_LO, VAR_LO));
		send_pixel('0, vpack(VAR_LO, VAR_HI, -VAR_HI, 1, -1));
		// Single scale, distinct steps: tie breaks, most negative variation
		// ranks above every other magnitude, zero still gets chosen.
		apply_config(3'd1, spack(100, 200, 300, 400, 500));
		send_pixel(pix_t'(1000), vpack(VAR_LO, VAR_HI, 5, -5, 5));
		send_pixel(pix_t'(1000), vpack(-5, 5, -5, 5, 7));
		send_pixel(pix_t'(-1000), vpack(0, 0, 0, 0, 0));
		// Division truncates toward zero for negative sums.
		apply_config(3'd3, spack(1, 1, 0, 0, 0));
		send_pixel(pix_t'(-7), vpack(-1, -1, -1, 9, 9));
		send_pixel(pix_t'(7), vpack(1, 1, 0, 9, 9));
		// Count of zero: pixel passes through, never flagged.
		apply_config(3'd0, {SCALES{AMT_MAX}});
		send_pixel(pix_t'(PIX_HI), vpack(VAR_HI, VAR_HI, VAR_HI, VAR_HI, VAR_HI));
		send_pixel(pix_t'(PIX_LO), vpack(VAR_LO, VAR_LO, VAR_LO, VAR_LO, VAR_LO));
		// Counts above the scale number clamp to all scales.
		apply_config(3'd6, spack(AMT_MAX, 1, 2, 3, 4));
		send_pixel(pix_t'(PIX_HI - 3), rand_vars());
		send_pixel(rand_pixel(), vpack(-3, 2, 0, VAR_LO, 1));
		apply_config(3'd7, spack(4, 3, 2, 1, AMT_MAX));
		send_pixel(pix_t'(PIX_LO + 3), rand_vars());
		send_pixel(rand_pixel(), vpack(3, -2, 0, VAR_HI, -1));
		// Zero steps: nothing moves even with two scales picked.
		apply_config(3'd2, '0);
		send_pixel(pix_t'(PIX_HI), vpack(VAR_HI, VAR_HI, VAR_HI, VAR_HI, VAR_HI));
	endtask

	// Writes past the register file must not disturb the live settings.
	task automatic test_spare_indexes();
		apply_config(3'd2, spack(1000, 2000, 3000, 4000, 5000));
		@(posedge clk);
		write_reg(IDX_SPARE_6, AMT_W'($urandom));
		write_reg(IDX_SPARE_7, AMT_W'($urandom));
		cfg_valid <= 1'b0;
		for (int i = 0; i < 4; i++)
			send_pixel(rand_pixel(), rand_vars());
	endtask

	// Random pixels under a fresh config per phase; every third phase
	// streams with no gaps on either side.
	task automatic test_random_phases();
		logic [CNT_W-1:0] sel;
		logic [AMT_W*SCALES-1:0] steps;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int i = 0; i < SCALES; i++)
				steps[i * AMT_W +: AMT_W] = rand_step();
			case (p)
				0: begin
					sel = 3'd5;
					steps = {SCALES{AMT_MAX}};
				end
				1: sel = 3'd0;
				2: begin
					sel = 3'd1;
					steps = '0;
				end
				3: sel = 3'd7;
				default: sel = CNT_W'($urandom_range(0, 7));
			endcase
			wait_drained();
			no_stall = (p % 3 == 2);
			apply_config(sel, steps);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_pixel(rand_pixel(), rand_vars());
		end
		wait_drained();
		no_stall = 1'b0;
	endtask

	initial begin
		shadow_select = SELECT_COUNT_RESET;
		for (int i = 0; i < SCALES; i++)
			shadow_steps[i] = STEP_AMOUNT_RESET;
		pixels_sent = 0;
		pixels_done = 0;
		mismatches  = 0;
		no_stall    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_special_cases();
		test_spare_indexes();
		test_random_phases();

		wait_drained();
		// Pipeline is five deep; give stray results a chance to show up.
		repeat (12) @(posedge clk);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
